/* rtl/cdr_pkg.sv */
package cdr_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned CfgW      = 32;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned HdrIdxW   = 4;
  localparam int unsigned HdrBytes  = 12;
  localparam int unsigned LabelW    = 6;
  localparam int unsigned NameLenW  = 8;
  localparam int unsigned TailW     = 3;
  localparam int unsigned TailNeed  = 4;
  localparam int unsigned TrlBytes  = 20;
  localparam int unsigned TrlIdxW   = 5;

  localparam int unsigned MaxNameLenDef  = 253;
  localparam int unsigned MaxLabelLenDef = 63;

  localparam logic [CfgW-1:0] AddrReset = 32'hC0A8_BC01;
  localparam logic [CfgW-1:0] TtlReset  = 32'd60;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ANSWER_ADDRESS = 1'b0,
    CFG_ANSWER_TTL     = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_CONTENT = 2'd2,
    PH_TAIL    = 2'd3
  } phase_e;

  // fixed question and answer record after the name, ttl and address spliced in
  function automatic logic [ByteW-1:0] trailer_byte(
    input logic [TrlIdxW-1:0] idx,
    input logic [CfgW-1:0]    ttl,
    input logic [CfgW-1:0]    addr
  );
    logic [ByteW-1:0] b;
    case (idx) inside
      5'd1, 5'd3, 5'd7, 5'd9: b = 8'h01;
      5'd4:  b = 8'hC0;
      5'd5:  b = 8'h0C;
      5'd10: b = ttl[31:24];
      5'd11: b = ttl[23:16];
      5'd12: b = ttl[15:8];
      5'd13: b = ttl[7:0];
      5'd15: b = 8'h04;
      5'd16: b = addr[31:24];
      5'd17: b = addr[23:16];
      5'd18: b = addr[15:8];
      5'd19: b = addr[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* rtl/cdr_if.sv */
interface cdr_in_if;
  logic                          valid;
  logic                          ready;
  logic [cdr_pkg::ByteW-1:0]     in_byte;
  logic                          in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface cdr_out_if;
  logic                          valid;
  logic                          ready;
  logic [cdr_pkg::ByteW-1:0]     out_byte;
  logic                          out_last;
  logic                          out_drop;

  modport source (output valid, output out_byte, output out_last, output out_drop,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input out_drop,
                  output ready);
endinterface

/* rtl/captive_dns_responder.sv */
// captive portal dns responder: takes the udp payload of a dns query one word
// (byte) per cycle and streams the answer frame out as the query goes by. the
// id is echoed, the header goes out as flags 0x8100, qdcount 1, ancount 1, and
// the encoded name is echoed with its terminator. each header and name word is
// parsed and its echo loaded straight into the output register, so a word is
// taken every cycle while the output side keeps up. on the final word of a
// good query a 20-word trailer follows (type a, class in, answer pointer
// 0xc00c, type a, class in, ttl, rdlength 4, address); the sequencer owns the
// output register until its last word is loaded, holding off input. a bad
// query (response bit set, qdcount not one, label over the limit, name over
// the limit, fewer than four words after the name) produces a single closing
// word with out_drop set, so downstream discards what it has of the frame.
// config writes take effect at once and are expected only between frames.
module captive_dns_responder #(
  parameter int unsigned MAX_NAME_LEN  = cdr_pkg::MaxNameLenDef,
  parameter int unsigned MAX_LABEL_LEN = cdr_pkg::MaxLabelLenDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cdr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cdr_pkg::CfgW-1:0]      cfg_data_i,
  cdr_in_if.sink                        in_s,
  cdr_out_if.source                     out_m
);

  // configuration
  logic [cdr_pkg::CfgW-1:0] addr_q, ttl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= cdr_pkg::AddrReset;
      ttl_q  <= cdr_pkg::TtlReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cdr_pkg::CFG_ANSWER_ADDRESS: addr_q <= cfg_data_i;
        cdr_pkg::CFG_ANSWER_TTL:     ttl_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // parser state
  cdr_pkg::phase_e                  phase_q, phase_d;
  logic [cdr_pkg::HdrIdxW-1:0]      hdr_idx_q, hdr_idx_d;
  logic [cdr_pkg::LabelW-1:0]       left_q, left_d;
  logic [cdr_pkg::NameLenW-1:0]     name_len_q, name_len_d;
  logic [cdr_pkg::TailW-1:0]        tail_q, tail_d;
  logic                             reject_q, reject_d;

  // trailer sequencer
  logic                             trl_active_q, trl_active_d;
  logic [cdr_pkg::TrlIdxW-1:0]      trl_idx_q, trl_idx_d;

  // output register
  logic                             out_valid_q, out_valid_d;
  logic [cdr_pkg::ByteW-1:0]        out_byte_q, out_byte_d;
  logic                             out_last_q, out_last_d;
  logic                             out_drop_q, out_drop_d;

  logic                             out_free;
  logic                             acc;
  logic                             got;
  logic [cdr_pkg::ByteW-1:0]        echo;
  logic [cdr_pkg::NameLenW+1:0]     name_sum;
  logic                             bad_end;

  assign out_free   = !out_valid_q || out_m.ready;
  assign in_s.ready = !trl_active_q && out_free;
  assign acc        = in_s.valid && in_s.ready;

  assign out_m.valid    = out_valid_q;
  assign out_m.out_byte = out_byte_q;
  assign out_m.out_last = out_last_q;
  assign out_m.out_drop = out_drop_q;

  // encoded name length if this length word is taken
  assign name_sum = {2'b00, name_len_q} + (cdr_pkg::NameLenW+2)'(1)
                  + {2'b00, in_s.in_byte};

  always_comb begin
    phase_d      = phase_q;
    hdr_idx_d    = hdr_idx_q;
    left_d       = left_q;
    name_len_d   = name_len_q;
    tail_d       = tail_q;
    reject_d     = reject_q;
    trl_active_d = trl_active_q;
    trl_idx_d    = trl_idx_q;
    out_valid_d  = out_valid_q;
    out_byte_d   = out_byte_q;
    out_last_d   = out_last_q;
    out_drop_d   = out_drop_q;
    got          = 1'b0;
    echo         = '0;
    bad_end      = 1'b0;

    if (out_free) begin
      out_valid_d = 1'b0;
    end

    // trailer words go out one per free cycle
    if (trl_active_q && out_free) begin
      out_valid_d = 1'b1;
      out_byte_d  = cdr_pkg::trailer_byte(trl_idx_q, ttl_q, addr_q);
      out_drop_d  = 1'b0;
      out_last_d  = (trl_idx_q == cdr_pkg::TrlIdxW'(cdr_pkg::TrlBytes - 1));
      trl_idx_d   = trl_idx_q + cdr_pkg::TrlIdxW'(1);
      if (out_last_d) begin
        trl_active_d = 1'b0;
      end
    end

    if (acc) begin
      if (!reject_q) begin
        case (phase_q)
          cdr_pkg::PH_HEADER: begin
            got = 1'b1;
            case (hdr_idx_q) inside
              4'd0, 4'd1: echo = in_s.in_byte;
              4'd2: begin
                echo = 8'h81;
                if (in_s.in_byte[7]) begin
                  reject_d = 1'b1;
                end
              end
              4'd4: begin
                if (in_s.in_byte != 8'h00) begin
                  reject_d = 1'b1;
                end
              end
              4'd5: begin
                echo = 8'h01;
                if (in_s.in_byte != 8'h01) begin
                  reject_d = 1'b1;
                end
              end
              4'd7: echo = 8'h01;
              default: echo = 8'h00;
            endcase
            if (reject_d) begin
              got = 1'b0;
            end else if (hdr_idx_q == cdr_pkg::HdrIdxW'(cdr_pkg::HdrBytes - 1)) begin
              hdr_idx_d = '0;
              phase_d   = cdr_pkg::PH_LENGTH;
            end else begin
              hdr_idx_d = hdr_idx_q + cdr_pkg::HdrIdxW'(1);
            end
          end
          cdr_pkg::PH_LENGTH: begin
            if (in_s.in_byte == 8'h00) begin
              got     = 1'b1;
              phase_d = cdr_pkg::PH_TAIL;
              tail_d  = '0;
            end else if ({2'b00, in_s.in_byte} > 10'(MAX_LABEL_LEN) ||
                         name_sum > (cdr_pkg::NameLenW+2)'(MAX_NAME_LEN)) begin
              reject_d = 1'b1;
            end else begin
              got        = 1'b1;
              echo       = in_s.in_byte;
              name_len_d = name_sum[cdr_pkg::NameLenW-1:0];
              left_d     = in_s.in_byte[cdr_pkg::LabelW-1:0];
              phase_d    = cdr_pkg::PH_CONTENT;
            end
          end
          cdr_pkg::PH_CONTENT: begin
            got  = 1'b1;
            echo = in_s.in_byte;
            if (left_q != '0) begin
              left_d = left_q - cdr_pkg::LabelW'(1);
            end
            if (left_d == '0) begin
              phase_d = cdr_pkg::PH_LENGTH;
            end
          end
          cdr_pkg::PH_TAIL: begin
            if (tail_q < cdr_pkg::TailW'(cdr_pkg::TailNeed)) begin
              tail_d = tail_q + cdr_pkg::TailW'(1);
            end
          end
          default: ;
        endcase
      end

      if (in_s.in_last) begin
        // a good frame ends in the tail with at least four words past the name
        bad_end = reject_d || phase_d != cdr_pkg::PH_TAIL ||
                  tail_d < cdr_pkg::TailW'(cdr_pkg::TailNeed);
        if (bad_end) begin
          out_valid_d = 1'b1;
          out_byte_d  = '0;
          out_last_d  = 1'b1;
          out_drop_d  = 1'b1;
        end else begin
          trl_active_d = 1'b1;
          trl_idx_d    = '0;
        end
        phase_d    = cdr_pkg::PH_HEADER;
        hdr_idx_d  = '0;
        left_d     = '0;
        name_len_d = '0;
        tail_d     = '0;
        reject_d   = 1'b0;
      end else if (got) begin
        out_valid_d = 1'b1;
        out_byte_d  = echo;
        out_last_d  = 1'b0;
        out_drop_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= cdr_pkg::PH_HEADER;
      hdr_idx_q    <= '0;
      left_q       <= '0;
      name_len_q   <= '0;
      tail_q       <= '0;
      reject_q     <= 1'b0;
      trl_active_q <= 1'b0;
      trl_idx_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      hdr_idx_q    <= hdr_idx_d;
      left_q       <= left_d;
      name_len_q   <= name_len_d;
      tail_q       <= tail_d;
      reject_q     <= reject_d;
      trl_active_q <= trl_active_d;
      trl_idx_q    <= trl_idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_drop_q <= out_drop_d;
  end

endmodule

/* tb/dns_answer_checker.sv */
`timescale 1ns / 100ps

module dns_answer_checker
  import cdr_pkg::*;
#(
  parameter int unsigned MAX_NAME_LEN  = MaxNameLenDef,
  parameter int unsigned MAX_LABEL_LEN = MaxLabelLenDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  cdr_in_if                  in_w,
  cdr_out_if                 out_w,
  output int unsigned        fail_cnt_o,
  output int unsigned        pending_o
);

  // header offsets with special treatment
  localparam logic [HdrIdxW-1:0] HdrIdHi    = 4'd0;
  localparam logic [HdrIdxW-1:0] HdrIdLo    = 4'd1;
  localparam logic [HdrIdxW-1:0] HdrFlagsHi = 4'd2;
  localparam logic [HdrIdxW-1:0] HdrQdHi    = 4'd4;
  localparam logic [HdrIdxW-1:0] HdrQdLo    = 4'd5;
  localparam logic [HdrIdxW-1:0] HdrAnLo    = 4'd7;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
    logic             drop;
  } answer_t;

  logic [CfgW-1:0]     addr_q;
  logic [CfgW-1:0]     ttl_q;
  logic [HdrIdxW-1:0]  hdr_idx;
  phase_e              phase;
  logic [LabelW-1:0]   label_left;
  logic [NameLenW-1:0] name_len;
  logic [TailW-1:0]    tail_cnt;
  logic                rejected;

  answer_t answer_q[$];
  answer_t head;

  task automatic clear_query();
    hdr_idx    = '0;
    phase      = PH_HEADER;
    label_left = '0;
    name_len   = '0;
    tail_cnt   = '0;
    rejected   = 1'b0;
  endtask

  function automatic logic [ByteW-1:0] trailer_at(input int j);
    logic [TrlBytes*ByteW-1:0] rec;
    // qtype a, qclass in, name pointer, type a, class in, ttl, rdlength, address
    rec = {16'h0001, 16'h0001, 16'hC00C, 16'h0001, 16'h0001, ttl_q, 16'h0004, addr_q};
    return rec[TrlBytes*ByteW-1-ByteW*j -: ByteW];
  endfunction

  task automatic predict_word(input logic [ByteW-1:0] b, input logic last);
    logic             got;
    logic [ByteW-1:0] echo;
    int unsigned      name_next;
    got  = 1'b0;
    echo = '0;
    name_next = int'(name_len) + 1 + int'(b);
    if (!rejected) begin
      case (phase)
        PH_HEADER: begin
          got = 1'b1;
          case (hdr_idx)
            HdrIdHi, HdrIdLo: echo = b;
            HdrFlagsHi: begin
              if (b[7]) rejected = 1'b1;
              else echo = 8'h81;
            end
            HdrQdHi: begin
              if (b != 8'h00) rejected = 1'b1;
              else echo = 8'h00;
            end
            HdrQdLo: begin
              if (b != 8'h01) rejected = 1'b1;
              else echo = 8'h01;
            end
            HdrAnLo: echo = 8'h01;
            default: echo = 8'h00;
          endcase
          if (rejected) begin
            got = 1'b0;
          end else if (hdr_idx == HdrBytes - 1) begin
            hdr_idx = '0;
            phase   = PH_LENGTH;
          end else begin
            hdr_idx = hdr_idx + 1'b1;
          end
        end
        PH_LENGTH: begin
          if (b == 8'h00) begin
            phase    = PH_TAIL;
            tail_cnt = '0;
            got      = 1'b1;
          end else if (int'(b) > MAX_LABEL_LEN || name_next > MAX_NAME_LEN) begin
            rejected = 1'b1;
          end else begin
            name_len   = name_next[NameLenW-1:0];
            label_left = b[LabelW-1:0];
            phase      = PH_CONTENT;
            got        = 1'b1;
            echo       = b;
          end
        end
        PH_CONTENT: begin
          if (label_left != 0) label_left--;
          if (label_left == 0) phase = PH_LENGTH;
          got  = 1'b1;
          echo = b;
        end
        default: begin
          if (tail_cnt < TailNeed) tail_cnt++;
        end
      endcase
    end

    if (!last) begin
      if (got) answer_q.push_back('{data: echo, last: 1'b0, drop: 1'b0});
    end else begin
      if (phase != PH_TAIL || tail_cnt < TailNeed) rejected = 1'b1;
      if (rejected) begin
        answer_q.push_back('{data: 8'h00, last: 1'b1, drop: 1'b1});
      end else begin
        if (got) answer_q.push_back('{data: echo, last: 1'b0, drop: 1'b0});
        for (int j = 0; j < TrlBytes; j++)
          answer_q.push_back('{data: trailer_at(j), last: (j == TrlBytes - 1), drop: 1'b0});
      end
      clear_query();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_query();
      answer_q.delete();
      addr_q     = AddrReset;
      ttl_q      = TtlReset;
      fail_cnt_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_ANSWER_ADDRESS: addr_q = cfg_data_i;
          CFG_ANSWER_TTL:     ttl_q  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_w.valid && in_w.ready) predict_word(in_w.in_byte, in_w.in_last);
      if (out_w.valid && out_w.ready) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected word %02h last %0b drop %0b", $time,
                   out_w.out_byte, out_w.out_last, out_w.out_drop);
          fail_cnt_o++;
        end else begin
          head = answer_q.pop_front();
          if (out_w.out_byte !== head.data) begin
            $display("%0t: out_byte expected %02h actual %02h", $time,
                     head.data, out_w.out_byte);
            fail_cnt_o++;
          end
          if (out_w.out_last !== head.last) begin
            $display("%0t: out_last expected %0b actual %0b", $time,
                     head.last, out_w.out_last);
            fail_cnt_o++;
          end
          if (out_w.out_drop !== head.drop) begin
            $display("%0t: out_drop expected %0b actual %0b", $time,
                     head.drop, out_w.out_drop);
            fail_cnt_o++;
          end
        end
      end
    end
    pending_o = answer_q.size();
  end

endmodule

/* tb/tb_captive_dns_responder.sv */
`timescale 1ns / 100ps

module tb_captive_dns_responder;

  // random part size in query words, split over the register settings
  localparam int RandWords     = 250;
  localparam int RandPhases    = 4;
  // trailer is 20 words, give the block room to go quiet
  localparam int SettleCycles  = 30;
  localparam int TimeoutCycles = 400_000;

  typedef enum int {
    QK_GOOD,
    QK_RESPONSE,
    QK_QDCOUNT,
    QK_LONG_LABEL,
    QK_LONG_NAME,
    QK_SHORT_TAIL,
    QK_TRUNCATED,
    QK_NOISE
  } query_kind_e;

  typedef enum int {
    SINK_OPEN,
    SINK_HALF,
    SINK_LIGHT,
    SINK_PERIODIC
  } sink_mode_e;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     cfg_we;
  cdr_pkg::cfg_reg_e        cfg_index;
  logic [cdr_pkg::CfgW-1:0] cfg_data;
  int unsigned              fail_cnt;
  int unsigned              pending;

  // query under construction, in wire order
  logic [cdr_pkg::ByteW-1:0] query_q[$];
  int               burst_left = 0;
  int               sent_words = 0;

  // receiver stall pattern state
  sink_mode_e       sink_mode  = SINK_OPEN;
  int               mode_left  = 0;
  logic [2:0]       stall_tick = '0;

  cdr_in_if  in_ch ();
  cdr_out_if out_ch ();

  captive_dns_responder u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_s        (in_ch),
    .out_m       (out_ch)
  );

  dns_answer_checker u_chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_w        (in_ch),
    .out_w       (out_ch),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: switches between open, heavy, light and periodic stalling
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1'b1;
    if (mode_left == 0) begin
      mode_left <= $urandom_range(20, 80);
      sink_mode <= sink_mode_e'($urandom_range(SINK_OPEN, SINK_PERIODIC));
    end else begin
      mode_left <= mode_left - 1;
    end
    case (sink_mode)
      SINK_OPEN:  out_ch.ready <= 1'b1;
      SINK_HALF:  out_ch.ready <= ($urandom_range(0, 1) == 1);
      SINK_LIGHT: out_ch.ready <= ($urandom_range(0, 7) != 0);
      default:    out_ch.ready <= (stall_tick[1:0] != 2'b00);
    endcase
  end

  // 12 header words: random id and spare fields, chosen flags and qdcount
  task automatic put_header(input logic [cdr_pkg::ByteW-1:0] flags_hi,
                            input logic [cdr_pkg::ByteW-1:0] qd_hi,
                            input logic [cdr_pkg::ByteW-1:0] qd_lo);
    query_q.push_back(8'($urandom));
    query_q.push_back(8'($urandom));
    query_q.push_back(flags_hi);
    query_q.push_back(8'($urandom));
    query_q.push_back(qd_hi);
    query_q.push_back(qd_lo);
    repeat (6) query_q.push_back(8'($urandom));
  endtask

  // length word then content; zero_fill gives an all-zero label
  task automatic put_label(input int len, input logic zero_fill);
    query_q.push_back(8'(len));
    repeat (len) begin
      if (zero_fill || $urandom_range(0, 7) == 0) query_q.push_back(8'h00);
      else query_q.push_back(8'($urandom));
    end
  endtask

  // name terminator followed by n words of type, class and padding
  task automatic put_tail(input int n);
    query_q.push_back(8'h00);
    repeat (n) query_q.push_back(8'($urandom));
  endtask

  // mostly short labels, now and then a long one
  task automatic put_random_name();
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 14) == 0) put_label($urandom_range(32, 63), 1'b0);
      else put_label($urandom_range(1, 9), 1'b0);
    end
  endtask

  // hand the built query to the block in bursts, in_last on the final word
  task automatic send_query();
    for (int i = 0; i < query_q.size(); i++) begin
      if (burst_left == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        // some bursts long enough to run with no idling at all
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 12);
      end
      in_ch.valid   <= 1'b1;
      in_ch.in_byte <= query_q[i];
      in_ch.in_last <= (i == query_q.size() - 1);
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      burst_left--;
      sent_words++;
    end
    query_q.delete();
  endtask

  task automatic random_query();
    int               pick;
    query_kind_e      kind;
    int               term_at;
    int               cut;
    logic [15:0]      qd;
    pick = $urandom_range(0, 99);
    if (pick < 65)      kind = QK_GOOD;
    else if (pick < 70) kind = QK_RESPONSE;
    else if (pick < 75) kind = QK_QDCOUNT;
    else if (pick < 80) kind = QK_LONG_LABEL;
    else if (pick < 82) kind = QK_LONG_NAME;
    else if (pick < 89) kind = QK_SHORT_TAIL;
    else if (pick < 96) kind = QK_TRUNCATED;
    else                kind = QK_NOISE;

    if (kind == QK_NOISE) begin
      repeat ($urandom_range(1, 20)) query_q.push_back(8'($urandom));
    end else begin
      if (kind == QK_RESPONSE) begin
        put_header(8'($urandom_range(128, 255)), 8'h00, 8'h01);
      end else if (kind == QK_QDCOUNT) begin
        qd = 16'($urandom);
        if (qd == 16'h0001) qd = 16'h0100;
        put_header(8'($urandom_range(0, 127)), qd[15:8], qd[7:0]);
      end else begin
        put_header(8'($urandom_range(0, 127)), 8'h00, 8'h01);
      end
      if (kind == QK_LONG_NAME) repeat (4) put_label(63, 1'b0);
      else put_random_name();
      // label length word over the limit, its content left out
      if (kind == QK_LONG_LABEL) query_q.push_back(8'($urandom_range(64, 255)));
      term_at = query_q.size();
      put_tail((kind == QK_SHORT_TAIL) ? $urandom_range(0, 3) : $urandom_range(4, 6));
      // cut somewhere before the terminator: header or name left unfinished
      if (kind == QK_TRUNCATED) begin
        cut = $urandom_range(1, term_at);
        while (query_q.size() > cut) void'(query_q.pop_back());
      end
    end
    send_query();
  endtask

  task automatic load_answer(input logic [cdr_pkg::CfgW-1:0] addr,
                             input logic [cdr_pkg::CfgW-1:0] ttl);
    cfg_we    <= 1'b1;
    cfg_index <= cdr_pkg::CFG_ANSWER_ADDRESS;
    cfg_data  <= addr;
    @(posedge clk);
    cfg_index <= cdr_pkg::CFG_ANSWER_TTL;
    cfg_data  <= ttl;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // all answers in, then let any trailing activity die away
  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= cdr_pkg::CFG_ANSWER_ADDRESS;
    cfg_data      <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= '0;
    in_ch.in_last <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed queries, registers at their reset values

    // minimal good query with the highest flags word that is still a query
    put_header(8'h7F, 8'h00, 8'h01);
    put_label(1, 1'b0);
    put_tail(4);
    send_query();
    // empty name, terminator straight after the header
    put_header(8'h00, 8'h00, 8'h01);
    put_tail(4);
    send_query();
    // zero words inside a label are echoed
    put_header(8'h01, 8'h00, 8'h01);
    put_label(3, 1'b1);
    put_tail(5);
    send_query();
    // longest label allowed and a long tail
    put_header(8'h7F, 8'h00, 8'h01);
    put_label(63, 1'b0);
    put_label(2, 1'b0);
    put_tail(7);
    send_query();
    // name exactly at the length limit
    put_header(8'h00, 8'h00, 8'h01);
    repeat (3) put_label(63, 1'b0);
    put_label(60, 1'b0);
    put_tail(4);
    send_query();
    // name one word over the limit
    put_header(8'h00, 8'h00, 8'h01);
    repeat (3) put_label(63, 1'b0);
    put_label(61, 1'b0);
    put_tail(4);
    send_query();
    // label one over the limit, then the largest length word
    put_header(8'h00, 8'h00, 8'h01);
    put_label(64, 1'b0);
    put_tail(4);
    send_query();
    put_header(8'h00, 8'h00, 8'h01);
    query_q.push_back(8'hFF);
    put_tail(4);
    send_query();
    // response bit set
    put_header(8'h80, 8'h00, 8'h01);
    put_label(2, 1'b0);
    put_tail(4);
    send_query();
    put_header(8'hFF, 8'h00, 8'h01);
    put_tail(4);
    send_query();
    // question count zero, then high count word set
    put_header(8'h00, 8'h00, 8'h00);
    put_tail(4);
    send_query();
    put_header(8'h00, 8'hFF, 8'h01);
    put_tail(4);
    send_query();
    // too few words after the name: none, then three
    put_header(8'h00, 8'h00, 8'h01);
    put_label(4, 1'b0);
    put_tail(0);
    send_query();
    put_header(8'h00, 8'h00, 8'h01);
    put_label(4, 1'b0);
    put_tail(3);
    send_query();
    // query ending inside the header
    put_header(8'h00, 8'h00, 8'h01);
    while (query_q.size() > 6) void'(query_q.pop_back());
    send_query();
    // query ending inside a label
    put_header(8'h00, 8'h00, 8'h01);
    put_label(5, 1'b0);
    void'(query_q.pop_back());
    void'(query_q.pop_back());
    send_query();
    // single word query
    query_q.push_back(8'hFF);
    send_query();
    in_ch.valid <= 1'b0;
    drain();

    // random queries, a new answer setting for each phase
    for (int ph = 0; ph < RandPhases; ph++) begin
      case (ph)
        0:       load_answer('0, '0);
        1:       load_answer('1, '1);
        default: load_answer(cdr_pkg::CfgW'($urandom), cdr_pkg::CfgW'($urandom));
      endcase
      for (int goal = sent_words + RandWords / RandPhases; sent_words < goal; )
        random_query();
      in_ch.valid <= 1'b0;
      drain();
    end

    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog against a hung handshake or missing answers
  initial begin
    #(TimeoutCycles * 10);
    $display("Test completed with failures");
    $finish;
  end

endmodule
